>>> rtl/cfpr_pkg.sv
// Shared constants, codes and the CRC-16 byte update for the framed packet receiver.
`timescale 1ns / 1ps
`default_nettype none
package cfpr_pkg;

   localparam int MAX_PARAM   = 32;
   localparam int LEN_INDEX   = 5;
   localparam int DEV_INDEX   = 1;
   localparam int TAIL_LEN    = 3;
   localparam int STORE_DEPTH = LEN_INDEX + 1 + MAX_PARAM + TAIL_LEN;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int LIM_W       = 6;

   localparam logic [15:0] CRC_POLY = 16'h8005;
   localparam logic [15:0] CRC_INIT = 16'h0202;

   typedef logic [7:0] byte_type;
   typedef logic [1:0] status_type;
   typedef logic [1:0] csr_index_type;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_BAD_END = 2'd1;
   localparam status_type ST_BAD_CRC = 2'd2;
   localparam status_type ST_BAD_DEV = 2'd3;

   localparam csr_index_type CSR_OWN_ID    = 2'd0;
   localparam csr_index_type CSR_START     = 2'd1;
   localparam csr_index_type CSR_END       = 2'd2;
   localparam csr_index_type CSR_MAX_PARAM = 2'd3;

   function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input byte_type b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

>>> rtl/cfpr_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module cfpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 41
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> rtl/crc16_framed_packet_receiver.sv
// Top level: framed packet receiver with CRC-16 check and frame replay.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel  ports                                        direction
//  req      req_valid, req_stall, req_rx_byte            byte in
//  rsp      rsp_valid, rsp_stall, rsp_frame_byte,        frame byte out
//           rsp_last_byte, rsp_frame_status
//  csr      csr_valid, csr_ready, csr_index, csr_data    register write
//
//  Receive bytes are taken one per cycle while req_stall is low; each frame byte goes
//  into the frame RAM and the CRC (the two received CRC bytes enter the CRC as zeros).
//  After the last tail byte the frame is replayed from the RAM; req_stall is high then.
//  A RAM read waits until the last byte reached the output register and that is free.
//  Reset is synchronous; the frame RAM needs no clearing.
//
module crc16_framed_packet_receiver (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire cfpr_pkg::byte_type       req_rx_byte,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output cfpr_pkg::byte_type            rsp_frame_byte,
   output logic                          rsp_last_byte,
   output cfpr_pkg::status_type          rsp_frame_status,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire cfpr_pkg::csr_index_type  csr_index,
   input  wire cfpr_pkg::byte_type       csr_data
);
   import cfpr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HEAD,
      S_PARAM,
      S_TAIL,
      S_REPLAY
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [LIM_W-1:0]  pcnt_ff, pcnt_in;
   logic [1:0]        tcnt_ff, tcnt_in;
   logic [15:0]       crc_ff, crc_in;
   byte_type          rcrc_lo_ff, rcrc_lo_in;
   byte_type          rcrc_hi_ff, rcrc_hi_in;
   byte_type          dev_ff, dev_in;
   logic [LIM_W-1:0]  len_ff, len_in;
   status_type        status_ff, status_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              rd_pend_ff, rd_pend_in;
   logic              rd_last_ff, rd_last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   byte_type          rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   status_type        rsp_status_ff, rsp_status_in;

   byte_type          own_id_ff, start_ff, end_ff;
   logic [LIM_W-1:0]  max_len_ff;

   logic              accept;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              rd_issue;
   byte_type          rd_data;
   logic [15:0]       crc_data, crc_zero;
   logic [LIM_W-1:0]  limit;
   logic [LIM_W-1:0]  pcnt_inc;
   logic              out_free;

   assign csr_ready        = 1'b1;
   assign req_stall        = (state_ff == S_REPLAY);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_byte   = rsp_byte_ff;
   assign rsp_last_byte    = rsp_last_ff;
   assign rsp_frame_status = rsp_status_ff;

   assign accept   = req_valid && !req_stall;
   assign crc_data = crc16_feed(crc_ff, req_rx_byte);
   assign crc_zero = crc16_feed(crc_ff, 8'h00);
   assign limit    = (max_len_ff > LIM_W'(MAX_PARAM)) ? LIM_W'(MAX_PARAM) : max_len_ff;
   assign pcnt_inc = pcnt_ff + 1'b1;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rd_issue = (state_ff == S_REPLAY) && !rd_pend_ff && (rd_idx_ff != cnt_ff) && out_free;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      pcnt_in       = pcnt_ff;
      tcnt_in       = tcnt_ff;
      crc_in        = crc_ff;
      rcrc_lo_in    = rcrc_lo_ff;
      rcrc_hi_in    = rcrc_hi_ff;
      dev_in        = dev_ff;
      len_in        = len_ff;
      status_in     = status_ff;
      rd_idx_in     = rd_idx_ff;
      rd_pend_in    = 1'b0;
      rd_last_in    = rd_last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = cnt_ff[ADDR_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept && req_rx_byte == start_ff) begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               cnt_in   = CNT_W'(1);
               pcnt_in  = '0;
               tcnt_in  = '0;
               crc_in   = crc16_feed(CRC_INIT, req_rx_byte);
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            if (accept && !(req_rx_byte == start_ff && cnt_ff == CNT_W'(1))) begin
               wr_en  = 1'b1;
               cnt_in = cnt_ff + 1'b1;
               crc_in = crc_data;
               if (cnt_ff == CNT_W'(DEV_INDEX)) begin
                  dev_in = req_rx_byte;
               end
               if (cnt_ff == CNT_W'(LEN_INDEX)) begin
                  len_in = req_rx_byte[LIM_W-1:0];
                  if (req_rx_byte > {{(8-LIM_W){1'b0}}, limit}) begin
                     state_in = S_IDLE;
                  end else if (req_rx_byte != 8'h00) begin
                     pcnt_in  = '0;
                     state_in = S_PARAM;
                  end else begin
                     tcnt_in  = '0;
                     state_in = S_TAIL;
                  end
               end
            end
         end
         S_PARAM: begin
            if (accept) begin
               wr_en   = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
               crc_in  = crc_data;
               pcnt_in = pcnt_inc;
               if (pcnt_inc >= len_ff) begin
                  pcnt_in  = '0;
                  tcnt_in  = '0;
                  state_in = S_TAIL;
               end
            end
         end
         S_TAIL: begin
            if (accept) begin
               wr_en   = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
               tcnt_in = tcnt_ff + 1'b1;
               if (tcnt_ff == 2'd0) begin
                  rcrc_lo_in = req_rx_byte;
                  crc_in     = crc_zero;
               end else if (tcnt_ff == 2'd1) begin
                  rcrc_hi_in = req_rx_byte;
                  crc_in     = crc_zero;
               end else begin
                  crc_in     = crc_data;
                  tcnt_in    = '0;
                  rd_idx_in  = '0;
                  state_in   = S_REPLAY;
                  if (dev_ff != own_id_ff) begin
                     status_in = ST_BAD_DEV;
                  end else if (req_rx_byte != end_ff) begin
                     status_in = ST_BAD_END;
                  end else if (crc_data != {rcrc_hi_ff, rcrc_lo_ff}) begin
                     status_in = ST_BAD_CRC;
                  end else begin
                     status_in = ST_OK;
                  end
               end
            end
         end
         S_REPLAY: begin
            if (rd_issue) begin
               rd_pend_in = 1'b1;
               rd_last_in = (rd_idx_ff == cnt_ff - 1'b1);
               rd_idx_in  = rd_idx_ff + 1'b1;
            end
            if (rd_pend_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = rd_data;
               rsp_last_in   = rd_last_ff;
               rsp_status_in = rd_last_ff ? status_ff : ST_OK;
               if (rd_last_ff) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         pcnt_ff       <= '0;
         tcnt_ff       <= '0;
         crc_ff        <= CRC_INIT;
         rd_idx_ff     <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         own_id_ff     <= 8'h00;
         start_ff      <= 8'h00;
         end_ff        <= 8'h00;
         max_len_ff    <= LIM_W'(32);
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         pcnt_ff       <= pcnt_in;
         tcnt_ff       <= tcnt_in;
         crc_ff        <= crc_in;
         rd_idx_ff     <= rd_idx_in;
         rd_pend_ff    <= rd_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_OWN_ID:    own_id_ff  <= csr_data;
               CSR_START:     start_ff   <= csr_data;
               CSR_END:       end_ff     <= csr_data;
               CSR_MAX_PARAM: max_len_ff <= csr_data[LIM_W-1:0];
               default: begin
               end
            endcase
         end
      end
      rcrc_lo_ff    <= rcrc_lo_in;
      rcrc_hi_ff    <= rcrc_hi_in;
      dev_ff        <= dev_in;
      len_ff        <= len_in;
      status_ff     <= status_in;
      rd_last_ff    <= rd_last_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   cfpr_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_rx_byte),
      .rd_en   (rd_issue),
      .rd_addr (rd_idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

endmodule
`default_nettype wire
